/* src/battery_voltage_monitor_macros.svh */
`ifndef BATTERY_VOLTAGE_MONITOR_MACROS_SVH
`define BATTERY_VOLTAGE_MONITOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define BVM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvm assertion failed");

// next-cycle implication, disabled in reset
`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvm assertion failed");

`endif

/* src/bvm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bvm_pkg;

  localparam int MV_W           = 16;
  localparam int HYST_W         = 10;
  localparam int CFG_IDX_W      = 8;
  localparam int RING_DEPTH_DEF = 16;
  localparam int CNT_W_DEF      = $clog2(RING_DEPTH_DEF + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = CFG_IDX_W'(3);

  localparam logic [MV_W-1:0]   PRESENT_RST  = MV_W'(10);
  localparam logic [MV_W-1:0]   WARNING_RST  = MV_W'(3400);
  localparam logic [MV_W-1:0]   CRITICAL_RST = MV_W'(3200);
  localparam logic [HYST_W-1:0] HYST_RST     = HYST_W'(100);

  typedef enum logic [1:0] {
    BAT_NONE = 2'd0,
    BAT_OK   = 2'd1,
    BAT_WARN = 2'd2,
    BAT_CRIT = 2'd3
  } bat_t;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_LOW  = 2'd1;
  localparam logic [1:0] BEEP_CRIT = 2'd2;

  typedef struct packed {
    logic load;
    logic update;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* src/bvm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module bvm_div import bvm_pkg::*; #(
  parameter int DVD_W = MV_W,
  parameter int DVS_W = CNT_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output logic                  done
);

  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DVS_W:0]    trial;
  logic [DVS_W+1:0]  diff;
  logic              fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DVD_W-2:0], fits};
      rem      <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* src/bvm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bvm_datapath import bvm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [MV_W-1:0]      voltage_sample,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MV_W-1:0]      cfg_data,
  input  wire logic                 result_stall,
  output logic                      result_valid,
  output logic [MV_W-1:0]           avg_voltage,
  output logic [1:0]                battery_status,
  output logic [1:0]                beep_request,
  output logic                      low_battery_failsafe,
  output logic                      clear_prevent_arming
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = MV_W + $clog2(RING_DEPTH);
  localparam int CMP_W = MV_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  logic [MV_W-1:0]   present_threshold;
  logic [MV_W-1:0]   warning_voltage;
  logic [MV_W-1:0]   critical_voltage;
  logic [HYST_W-1:0] hysteresis;

  logic [MV_W-1:0]  ring [RING_DEPTH];
  logic [MV_W-1:0]  ring_rd;
  logic [MV_W-1:0]  sample_q;
  logic [MV_W-1:0]  old_sample;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic [IDX_W-1:0] write_index;
  logic [CNT_W-1:0] fill_count;

  logic [SUM_W-1:0] quo;
  logic             div_done;
  logic [MV_W-1:0]  avg;

  bat_t             monitor_state;
  bat_t             present_state;
  bat_t             state_next;
  logic [1:0]       beep;
  logic             failsafe;
  logic             clear;

  logic signed [CMP_W-1:0] a_s;
  logic signed [CMP_W-1:0] hy_s;
  logic signed [CMP_W-1:0] warn_lo;
  logic signed [CMP_W-1:0] warn_hi;
  logic signed [CMP_W-1:0] crit_lo;
  logic signed [CMP_W-1:0] crit_hi;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      present_threshold <= PRESENT_RST;
      warning_voltage   <= WARNING_RST;
      critical_voltage  <= CRITICAL_RST;
      hysteresis        <= HYST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRESENT:  present_threshold <= cfg_data;
        CFG_WARNING:  warning_voltage   <= cfg_data;
        CFG_CRITICAL: critical_voltage  <= cfg_data;
        CFG_HYST:     hysteresis        <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_rd  <= ring[write_index];
      sample_q <= voltage_sample;
    end
    if (cmd.update) begin
      ring[write_index] <= sample_q;
    end
  end

  // slots are written in order, so an unwritten slot reads as zero until full
  assign old_sample       = (fill_count == FULL_CNT) ? ring_rd : '0;
  assign running_sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      write_index <= '0;
      fill_count  <= '0;
    end else if (cmd.update) begin
      running_sum <= running_sum_next;
      write_index <= (write_index == LAST_IDX) ? '0 : write_index + IDX_W'(1);
      if (fill_count != FULL_CNT) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  bvm_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_sum),
    .divisor  (fill_count),
    .quotient (quo),
    .done     (div_done)
  );

  assign avg = quo[MV_W-1:0];

  // battery state decision
  assign a_s     = $signed({2'b00, avg});
  assign hy_s    = $signed({{(CMP_W - HYST_W){1'b0}}, hysteresis});
  assign warn_lo = $signed({2'b00, warning_voltage}) - hy_s;
  assign warn_hi = $signed({2'b00, warning_voltage}) + hy_s;
  assign crit_lo = $signed({2'b00, critical_voltage}) - hy_s;
  assign crit_hi = $signed({2'b00, critical_voltage}) + hy_s;

  always_comb begin
    present_state = monitor_state;
    if (monitor_state == BAT_NONE && avg > present_threshold) begin
      present_state = BAT_OK;
    end else if (monitor_state != BAT_NONE && avg <= present_threshold) begin
      present_state = BAT_NONE;
    end
    state_next = present_state;
    beep       = BEEP_NONE;
    failsafe   = 1'b0;
    clear      = 1'b0;
    unique case (present_state)
      BAT_OK: begin
        if (a_s <= warn_lo) begin
          state_next = BAT_WARN;
          beep       = BEEP_LOW;
        end
      end
      BAT_WARN: begin
        clear    = 1'b1;
        failsafe = 1'b1;
        if (a_s <= crit_lo) begin
          state_next = BAT_CRIT;
          beep       = BEEP_CRIT;
        end else if (a_s > warn_hi) begin
          state_next = BAT_OK;
        end else begin
          beep = BEEP_LOW;
        end
      end
      BAT_CRIT: begin
        failsafe = 1'b1;
        if (a_s > crit_hi) begin
          state_next = BAT_WARN;
          beep       = BEEP_LOW;
        end else begin
          beep = BEEP_CRIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_state <= BAT_NONE;
    end else if (cmd.finish) begin
      monitor_state <= state_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      avg_voltage          <= avg;
      battery_status       <= state_next;
      beep_request         <= beep;
      low_battery_failsafe <= failsafe;
      clear_prevent_arming <= clear;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !result_valid || !result_stall;

endmodule
`default_nettype wire

/* src/bvm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bvm_ctrl import bvm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic sample_valid,
  output logic      sample_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_START  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    sample_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/battery_voltage_monitor.sv */
// Battery voltage monitor.
// Sample channel: voltage_sample with sample_valid / sample_stall; a word is
// taken when sample_valid is high and sample_stall is low. Result channel:
// avg_voltage, battery_status, beep_request, low_battery_failsafe and
// clear_prevent_arming with result_valid / result_stall, one word per sample.
// Config channel: cfg_index / cfg_data with cfg_valid / cfg_ready, always
// ready; indexes 0..3 are present, warning, critical and hysteresis, others
// are dropped. Write config only while no sample is in flight.
// The sample passes the load, update, divider-start, divide and finish states
// before result_valid rises; the running sum is SUM_W = 16 + log2(RING_DEPTH)
// bits wide, and the pace of samples is set by the bit-serial divider of the
// running sum by the fill count, one bit a cycle.
// Samples are taken one at a time; the next one is taken while the previous
// result waits in the output register.
// Reset: ring sum, fill count and write index clear, state goes to not
// present, thresholds return to 10, 3400, 3200 and 100 mV.
// Stall: a held result stays stable; a finished word waits until the
// output register frees, and sample_stall stays high until then.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_voltage_monitor_macros.svh"
module battery_voltage_monitor import bvm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  input  wire logic [MV_W-1:0]      voltage_sample,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [MV_W-1:0]           avg_voltage,
  output logic [1:0]                battery_status,
  output logic [1:0]                beep_request,
  output logic                      low_battery_failsafe,
  output logic                      clear_prevent_arming,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MV_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bvm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  bvm_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .voltage_sample       (voltage_sample),
    .cfg_valid            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .result_stall         (result_stall),
    .result_valid         (result_valid),
    .avg_voltage          (avg_voltage),
    .battery_status       (battery_status),
    .beep_request         (beep_request),
    .low_battery_failsafe (low_battery_failsafe),
    .clear_prevent_arming (clear_prevent_arming)
  );

  `BVM_ASSERT_NEXT(a_busy_after_take, clk, rst, sample_valid && !sample_stall, sample_stall)
  `BVM_ASSERT_NOW(a_clear_needs_failsafe, clk, rst, result_valid && clear_prevent_arming, low_battery_failsafe)
  `BVM_ASSERT_NOW(a_absent_quiet, clk, rst, result_valid && battery_status == BAT_NONE, beep_request == BEEP_NONE && !low_battery_failsafe)
  `BVM_ASSERT_NOW(a_beep_code, clk, rst, result_valid, beep_request == BEEP_NONE || beep_request == BEEP_LOW || beep_request == BEEP_CRIT)

endmodule
`default_nettype wire
